@@ rtl/core/pic_pkg.sv @@
// Package for the padded image CRC-32 block: widths, constants, word types
// and the sequencer state type. No dependencies.
package pic_pkg;

   localparam int COUNT_BITS = 22;
   localparam int FLASH_BITS = 22;
   localparam int TOTAL_BITS = 22;
   localparam int CRC_BITS   = 32;
   localparam int EXT_BITS   = 33;

   localparam logic [CRC_BITS-1:0] CRC_POLY  = 32'hEDB8_8320;
   localparam logic [7:0]          FILL_BYTE = 8'hFF;

   localparam logic [EXT_BITS-1:0] COUNT_MAX_EXT = (EXT_BITS'(1) << COUNT_BITS) - EXT_BITS'(1);
   localparam logic [EXT_BITS-1:0] TOTAL_MAX_EXT = (EXT_BITS'(1) << TOTAL_BITS) - EXT_BITS'(1);

   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [CRC_BITS-1:0]   image_crc;
      logic [TOTAL_BITS-1:0] total_bytes;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_DONE
   } state_type;

endpackage

@@ rtl/core/pic_crc_fold.sv @@
// Byte-wide reflected CRC-32 fold, eight bit steps of polynomial 0xEDB88320.
// Depends on pic_pkg.
module pic_crc_fold (
   input  logic [pic_pkg::CRC_BITS-1:0] crc_in,
   input  logic [7:0]                   byte_in,
   output logic [pic_pkg::CRC_BITS-1:0] crc_out
);
   import pic_pkg::*;

   always_comb begin
      logic [CRC_BITS-1:0] acc;
      acc = crc_in ^ {{(CRC_BITS-8){1'b0}}, byte_in};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_out = acc;
   end

endmodule

@@ rtl/core/pic_ctrl.sv @@
// Sequencer for the padded image CRC: feeds image bytes, then fill bytes,
// through one shared byte-fold unit and holds the result word.
// Depends on pic_pkg and pic_crc_fold.
module pic_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pic_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pic_pkg::rsp_type    rsp_data,
   input  pic_pkg::count_type  fill_target
);
   import pic_pkg::*;

   state_type            state_ff, state_in;
   logic [CRC_BITS-1:0]  crc_ff, crc_in;
   count_type            count_ff, count_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [7:0]           fold_byte;
   logic [CRC_BITS-1:0]  fold_crc;
   logic [EXT_BITS-1:0]  count_ext;
   logic [TOTAL_BITS-1:0] total_sat;
   logic                 count_full;

   pic_crc_fold u_fold (
      .crc_in  (crc_ff),
      .byte_in (fold_byte),
      .crc_out (fold_crc)
   );

   assign count_ext  = EXT_BITS'(count_ff);
   assign count_full = (count_ext == COUNT_MAX_EXT);
   assign total_sat  = (count_ext > TOTAL_MAX_EXT) ? TOTAL_BITS'(TOTAL_MAX_EXT)
                                                   : TOTAL_BITS'(count_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         crc_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         crc_ff   <= crc_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in    = state_ff;
      crc_in      = crc_ff;
      count_in    = count_ff;
      rsp_data_in = rsp_data_ff;
      fold_byte   = FILL_BYTE;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            fold_byte = req_data.data_byte;
            if (req_valid) begin
               crc_in   = fold_crc;
               count_in = count_full ? count_ff : count_ff + count_type'(1);
               if (req_data.last) begin
                  state_in = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            if (count_ff < fill_target) begin
               crc_in   = fold_crc;
               count_in = count_ff + count_type'(1);
            end else begin
               rsp_data_in.image_crc   = crc_ff;
               rsp_data_in.total_bytes = total_sat;
               crc_in   = '0;
               count_in = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_data = rsp_data_ff;

   // running state is already cleared while the result word waits
   a_clear_on_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> (crc_ff == '0 && count_ff == '0))
      else $error("crc/count not cleared while result pending");

   // a fill step never overshoots the target
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && $past(state_ff) == ST_FILL && !$past(reset))
      |-> count_ff <= fill_target)
      else $error("fill count passed target");

   // a result word only appears at the end of the fill loop
   a_done_from_fill: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid) && !$past(reset)) |-> $past(state_ff) == ST_FILL)
      else $error("result word without fill phase");

endmodule

@@ rtl/core/padded_image_crc32.sv @@
// Top level of the padded image CRC-32 block: flash size register, fill
// target clamp and the sequencer. Depends on pic_pkg and pic_ctrl.

// Takes one image byte per word and folds it into a reflected CRC-32
// (polynomial 0xEDB88320, start 0, no final inversion). A byte without last
// is accepted and the block is ready again the next cycle. The
// byte marked last starts the fill loop: 0xFF bytes are folded one per cycle
// through the same byte-fold unit until the count reaches min(flash_size,
// counter maximum); then the result word (CRC and byte total) is offered,
// and the input stays stalled until the result word is taken. The one
// byte-fold unit sets the rate: one byte, image or fill, per cycle, save
// while the result word is formed or waits. flash_size is written through
// csr_wr_en / csr_wr_data and should only change while no image is in progress.
module padded_image_crc32 (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pic_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pic_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [pic_pkg::FLASH_BITS-1:0] csr_wr_data
);
   import pic_pkg::*;

   logic [FLASH_BITS-1:0] flash_size_ff, flash_size_in;
   logic [EXT_BITS-1:0]   flash_ext;
   count_type             fill_target;

   assign flash_size_in = csr_wr_en ? csr_wr_data : flash_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flash_size_ff <= '0;
      end else begin
         flash_size_ff <= flash_size_in;
      end
   end

   // fill stops where the byte counter saturates
   assign flash_ext   = EXT_BITS'(flash_size_ff);
   assign fill_target = (flash_ext > COUNT_MAX_EXT) ? COUNT_BITS'(COUNT_MAX_EXT)
                                                    : COUNT_BITS'(flash_ext);

   pic_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fill_target (fill_target)
   );

endmodule
